@@ hdl/alpha_bounding_box_trim_defines.svh @@
// Assertion macros for the alpha bounding-box trim block.
// Depends on nothing; included by the top level.
`ifndef ALPHA_BOUNDING_BOX_TRIM_DEFINES_SVH
`define ALPHA_BOUNDING_BOX_TRIM_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ABBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ABBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/abbt_pkg.sv @@
// Shared types and constants of the alpha bounding-box trim block.
// No dependencies.
package abbt_pkg;

    localparam int CFG_W   = 13;
    localparam int ALPHA_W = 8;
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;

    // Both frame size registers come out of reset at this size.
    localparam int CFG_RESET = 4096;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [POS_W-1:0]  left_x;
        logic [POS_W-1:0]  top_y;
        logic [SIZE_W-1:0] trimmed_width;
        logic [SIZE_W-1:0] trimmed_height;
        logic              empty_frame;
    } t_box;

endpackage

@@ hdl/abbt_if.sv @@
// Valid/ready channels of the alpha bounding-box trim block: pixel in, box out.
// Depends on abbt_pkg.
interface abbt_pix_if import abbt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ALPHA_W-1:0] alpha;

    modport source (output valid, output alpha, input ready);
    modport sink   (input valid, input alpha, output ready);
endinterface

interface abbt_box_if import abbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  left_x;
    logic [POS_W-1:0]  top_y;
    logic [SIZE_W-1:0] trimmed_width;
    logic [SIZE_W-1:0] trimmed_height;
    logic              empty_frame;

    modport source (output valid, output left_x, output top_y, output trimmed_width,
                    output trimmed_height, output empty_frame, input ready);
    modport sink   (input valid, input left_x, input top_y, input trimmed_width,
                    input trimmed_height, input empty_frame, output ready);
endinterface

@@ hdl/abbt_cfg.sv @@
// Frame size registers: clamp each written size and hold the last index.
// Depends on abbt_pkg.
module abbt_cfg import abbt_pkg::*; #(
    parameter int MAX_DIM = 4096,
    parameter int CW      = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_reg         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic [CW-1:0]    o_w_last,
    output logic [CW-1:0]    o_h_last
);

    localparam int DimCap  = (MAX_DIM < (2**CFG_W - 1)) ? MAX_DIM : (2**CFG_W - 1);
    localparam int RstDim  = (CFG_RESET > DimCap) ? DimCap : CFG_RESET;
    localparam logic [CW-1:0] RstLast = CW'(RstDim - 1);

    logic [CW-1:0] r_w_last, r_h_last;
    logic [CW-1:0] n_last;

    // Size zero acts as one, anything above the cap acts as the cap.
    always_comb begin
        if (i_cfg_data == '0) begin
            n_last = '0;
        end else if (32'(i_cfg_data) > DimCap) begin
            n_last = CW'(DimCap - 1);
        end else begin
            n_last = CW'(i_cfg_data - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= RstLast;
            r_h_last <= RstLast;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_w_last <= n_last;
                REG_FRAME_HEIGHT: r_h_last <= n_last;
                default:          r_w_last <= r_w_last;
            endcase
        end
    end

    assign o_w_last = r_w_last;
    assign o_h_last = r_h_last;

endmodule

@@ hdl/abbt_track.sv @@
// Raster position counters and nonzero-alpha bounds, plus the box they give.
// Depends on abbt_pkg.
module abbt_track import abbt_pkg::*; #(
    parameter int CW = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [ALPHA_W-1:0] i_alpha,
    input  logic [CW-1:0]      i_w_last,
    input  logic [CW-1:0]      i_h_last,
    output logic               o_frame_end,
    output t_box               o_box
);

    logic [CW-1:0] r_col, r_row, r_min_col, r_max_col, r_first_row, r_last_row;
    logic          r_seen;
    logic [CW-1:0] n_min_col, n_max_col, n_first_row, n_last_row;
    logic          n_seen;
    logic          row_end;
    logic [CW:0]   span_x, span_y;

    assign row_end     = (r_col >= i_w_last);
    assign o_frame_end = row_end && (r_row >= i_h_last);

    always_comb begin
        n_seen      = r_seen;
        n_min_col   = r_min_col;
        n_max_col   = r_max_col;
        n_first_row = r_first_row;
        n_last_row  = r_last_row;
        if (i_alpha != '0) begin
            n_seen     = 1'b1;
            n_last_row = r_row;
            if (!r_seen) begin
                n_min_col   = r_col;
                n_max_col   = r_col;
                n_first_row = r_row;
            end else begin
                if (r_col < r_min_col) n_min_col = r_col;
                if (r_col > r_max_col) n_max_col = r_col;
            end
        end
    end

    assign span_x = {1'b0, n_max_col} - {1'b0, n_min_col} + (CW+1)'(1);
    assign span_y = {1'b0, n_last_row} - {1'b0, n_first_row} + (CW+1)'(1);

    always_comb begin
        if (n_seen) begin
            o_box.left_x         = POS_W'(n_min_col);
            o_box.top_y          = POS_W'(n_first_row);
            o_box.trimmed_width  = SIZE_W'(span_x);
            o_box.trimmed_height = SIZE_W'(span_y);
            o_box.empty_frame    = 1'b0;
        end else begin
            o_box                = '0;
            o_box.empty_frame    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_seen      <= 1'b0;
            r_min_col   <= '0;
            r_max_col   <= '0;
            r_first_row <= '0;
            r_last_row  <= '0;
        end else if (i_step) begin
            if (o_frame_end) begin
                r_col       <= '0;
                r_row       <= '0;
                r_seen      <= 1'b0;
                r_min_col   <= '0;
                r_max_col   <= '0;
                r_first_row <= '0;
                r_last_row  <= '0;
            end else begin
                r_seen      <= n_seen;
                r_min_col   <= n_min_col;
                r_max_col   <= n_max_col;
                r_first_row <= n_first_row;
                r_last_row  <= n_last_row;
                if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

endmodule

@@ hdl/alpha_bounding_box_trim.sv @@
// Alpha bounding-box trim: one alpha byte per request in raster order, one box per frame.
// Throughput: one pixel per cycle; a frame's last pixel stalls while an untaken box is held.
// Pixels pass the input register into the bounds; a frame's box waits in the result register.
// Synchronous active-low reset clears the pipeline, counters, bounds and sets both sizes to 4096.
// Depends on abbt_pkg, abbt_if, abbt_cfg, abbt_track and the assertion macro header.
`include "alpha_bounding_box_trim_defines.svh"

module alpha_bounding_box_trim import abbt_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    abbt_pix_if.sink         i_pix,
    abbt_box_if.source       o_box,
    input  logic             i_cfg_we,
    input  t_cfg_reg         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // Counters only ever reach the clamped size minus one.
    localparam int DimCap = (MAX_DIM < (2**CFG_W - 1)) ? MAX_DIM : (2**CFG_W - 1);
    localparam int CW     = $clog2(DimCap);

    logic [CW-1:0]      w_last, h_last;
    logic               r_s1_valid;
    logic [ALPHA_W-1:0] r_s1_alpha;
    logic               r_out_valid;
    t_box               r_box;
    t_box               box;
    logic               frame_end;
    logic               out_free;
    logic               s1_adv;
    logic               s1_fire;
    logic               in_fire;

    abbt_cfg #(
        .MAX_DIM (MAX_DIM),
        .CW      (CW)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_w_last   (w_last),
        .o_h_last   (h_last)
    );

    abbt_track #(
        .CW (CW)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_fire),
        .i_alpha     (r_s1_alpha),
        .i_w_last    (w_last),
        .i_h_last    (h_last),
        .o_frame_end (frame_end),
        .o_box       (box)
    );

    // Only the last pixel of a frame needs room in the result register;
    // every other pixel advances even while a box waits to be taken.
    assign out_free    = !r_out_valid || o_box.ready;
    assign s1_adv      = !frame_end || out_free;
    assign s1_fire     = r_s1_valid && s1_adv;
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign in_fire     = i_pix.valid && i_pix.ready;

    // Input register: load on each request, drop once consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_alpha <= i_pix.alpha;
        end
    end

    // Result register: capture the box at frame end, hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && frame_end) begin
            r_out_valid <= 1'b1;
        end else if (o_box.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && frame_end) begin
            r_box <= box;
        end
    end

    assign o_box.valid          = r_out_valid;
    assign o_box.left_x         = r_box.left_x;
    assign o_box.top_y          = r_box.top_y;
    assign o_box.trimmed_width  = r_box.trimmed_width;
    assign o_box.trimmed_height = r_box.trimmed_height;
    assign o_box.empty_frame    = r_box.empty_frame;

    // A frame's last pixel always leaves a box behind.
    `ABBT_ASSERT_NEXT(a_frame_end_gives_box, i_clk, i_rst_n, s1_fire && frame_end, r_out_valid, "frame end did not produce a box")
    // An empty frame reports an all-zero box.
    `ABBT_ASSERT_NOW(a_empty_box_zero, i_clk, i_rst_n, r_out_valid && r_box.empty_frame, r_box.left_x == '0 && r_box.top_y == '0 && r_box.trimmed_width == '0 && r_box.trimmed_height == '0, "empty frame box not zero")
    // A non-empty frame has a box of at least one pixel.
    `ABBT_ASSERT_NOW(a_box_nonzero, i_clk, i_rst_n, r_out_valid && !r_box.empty_frame, r_box.trimmed_width != '0 && r_box.trimmed_height != '0, "non-empty box has zero size")
    // An accepted pixel lands in the input register.
    `ABBT_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, in_fire, r_s1_valid, "accepted pixel lost")

endmodule

@@ tb/abbt_box_checker.sv @@
// Checker for the alpha bounding-box trim block: watches the pixel, box and register ports,
// predicts each frame's box and compares it field by field. Depends on abbt_pkg and abbt_if.
module abbt_box_checker import abbt_pkg::*; #(
    parameter int MAX_DIM = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    abbt_pix_if              pix,
    abbt_box_if              box,
    input  logic             i_cfg_we,
    input  t_cfg_reg         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_box_count,
    output int               o_empty_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0] frame_w;
    logic [CFG_W-1:0] frame_h;
    int   col_cnt;
    int   row_cnt;
    bit   opaque_seen;
    int   col_lo;
    int   col_hi;
    int   row_lo;
    int   row_hi;

    t_box box_due[$];
    int   fail_count  = 0;
    int   box_count   = 0;
    int   empty_count = 0;

    assign o_fail_count  = fail_count;
    assign o_box_count   = box_count;
    assign o_empty_count = empty_count;

    function automatic int eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic void clear_bounds();
        col_cnt     = 0;
        row_cnt     = 0;
        opaque_seen = 1'b0;
        col_lo      = 0;
        col_hi      = 0;
        row_lo      = 0;
        row_hi      = 0;
    endfunction

    // Fold one pixel into the bounds; return 1 with the box when it closes the frame.
    function automatic bit fold_pixel(input logic [ALPHA_W-1:0] a, output t_box res);
        int w;
        int h;
        bit row_done;
        bit frame_done;
        w          = eff_dim(frame_w);
        h          = eff_dim(frame_h);
        row_done   = col_cnt >= w - 1;
        frame_done = row_done && (row_cnt >= h - 1);
        if (a != '0) begin
            if (!opaque_seen) begin
                opaque_seen = 1'b1;
                col_lo      = col_cnt;
                col_hi      = col_cnt;
                row_lo      = row_cnt;
            end else begin
                if (col_cnt < col_lo)
                    col_lo = col_cnt;
                if (col_cnt > col_hi)
                    col_hi = col_cnt;
            end
            row_hi = row_cnt;
        end
        res = '0;
        if (frame_done) begin
            if (opaque_seen) begin
                res.left_x         = POS_W'(col_lo);
                res.top_y          = POS_W'(row_lo);
                res.trimmed_width  = SIZE_W'(col_hi - col_lo + 1);
                res.trimmed_height = SIZE_W'(row_hi - row_lo + 1);
            end else begin
                res.empty_frame = 1'b1;
            end
            clear_bounds();
            return 1'b1;
        end
        if (row_done) begin
            col_cnt = 0;
            row_cnt = row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input int want, input int seen);
        if (want != seen) begin
            $error("box field %s: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_box want;
        t_box predicted;
        if (!i_rst_n) begin
            frame_w = CFG_W'(CFG_RESET);
            frame_h = CFG_W'(CFG_RESET);
            clear_bounds();
            box_due.delete();
        end else begin
            // Retire the box first: a box for a pixel taken at this edge cannot leave yet.
            if (box.valid && box.ready) begin
                if (box_due.size() == 0) begin
                    $error("box with no frame closed: left_x %0d top_y %0d", box.left_x,
                           box.top_y);
                    fail_count++;
                end else begin
                    want = box_due.pop_front();
                    check_field("left_x", want.left_x, box.left_x);
                    check_field("top_y", want.top_y, box.top_y);
                    check_field("trimmed_width", want.trimmed_width, box.trimmed_width);
                    check_field("trimmed_height", want.trimmed_height, box.trimmed_height);
                    check_field("empty_frame", want.empty_frame, box.empty_frame);
                    box_count++;
                    if (want.empty_frame)
                        empty_count++;
                end
            end
            if (pix.valid && pix.ready) begin
                if (fold_pixel(pix.alpha, predicted))
                    box_due.push_back(predicted);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH:  frame_w = i_cfg_data;
                    REG_FRAME_HEIGHT: frame_h = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= box_due.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the alpha bounding-box trim testbench: clock, reset, register writes, pixel and
// box traffic, watchdog and verdict. Uses abbt_pkg, abbt_if, the DUT and abbt_box_checker.
module tb_top;
    import abbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM       = 4096;
    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 4;      // lets the last box clear the result register
    localparam int END_CYCLES    = 20;
    localparam int QUIET_LIMIT   = 5000;   // cycles with no request taken on either side
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 1200;
    localparam int PART_PIXELS   = 12;     // pixels run under an out-of-range size

    // Shapes of alpha content inside one frame.
    typedef enum int {
        FILL_EMPTY,
        FILL_SPARSE,
        FILL_DENSE,
        FILL_BLOB,
        FILL_EDGES,
        FILL_CORNER
    } t_fill;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    t_cfg_reg         cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int box_count;
    int empty_count;

    abbt_pix_if pix_if ();
    abbt_box_if box_if ();

    alpha_bounding_box_trim #(
        .MAX_DIM (MAX_DIM)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_box      (box_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    abbt_box_checker #(
        .MAX_DIM (MAX_DIM)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .pix           (pix_if),
        .box           (box_if),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_box_count   (box_count),
        .o_empty_count (empty_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Traffic shaping shared by the stimulus and the receiver.
    bit tx_burst  = 1'b0;   // sender offers back to back
    bit rx_burst  = 1'b0;   // receiver takes no random stalls
    int hold_off  = 0;      // long receiver hold-off, consumed by the receiver process

    // Stimulus-side view of the frame geometry, used to know where a frame ends.
    int    eff_w;
    int    eff_h;
    int    pos_c;
    int    pos_r;
    t_fill fill;
    int    blob_x0;
    int    blob_x1;
    int    blob_y0;
    int    blob_y1;
    int    pixels_sent  = 0;
    int    setting_count = 0;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int clamp_size(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // Small sizes for the bulk of the run; zero shows up now and then to act as one.
    function automatic logic [CFG_W-1:0] rand_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 70)
            return CFG_W'($urandom_range(1, 8));
        if (r < 92)
            return CFG_W'($urandom_range(9, 24));
        return CFG_W'($urandom_range(25, 64));
    endfunction

    function automatic logic [CFG_W-1:0] rand_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 70)
            return CFG_W'($urandom_range(1, 6));
        return CFG_W'($urandom_range(7, 16));
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        logic [ALPHA_W-1:0] lit;
        bit last_pix;
        bit first_pix;
        bit in_blob;
        bit blob_corner;
        lit         = ALPHA_W'($urandom_range(1, 255));
        first_pix   = (pos_c == 0) && (pos_r == 0);
        last_pix    = (pos_c >= eff_w - 1) && (pos_r >= eff_h - 1);
        in_blob     = (pos_c >= blob_x0) && (pos_c <= blob_x1) &&
                      (pos_r >= blob_y0) && (pos_r <= blob_y1);
        blob_corner = ((pos_c == blob_x0) && (pos_r == blob_y0)) ||
                      ((pos_c == blob_x1) && (pos_r == blob_y1));
        case (fill)
            FILL_EMPTY:  return '0;
            FILL_SPARSE: return ($urandom_range(0, 99) < 8) ? lit : '0;
            FILL_DENSE:  return ($urandom_range(0, 99) < 60) ? lit : '0;
            FILL_BLOB: begin
                if (blob_corner || (in_blob && $urandom_range(0, 99) < 75) ||
                    $urandom_range(0, 99) < 2)
                    return lit;
                return '0;
            end
            FILL_EDGES:  return (first_pix || last_pix) ? lit : '0;
            FILL_CORNER: return last_pix ? lit : '0;
            default:     return '0;
        endcase
    endfunction

    // Offer one pixel request, wait for it to be taken, and advance the raster position.
    // Called and returns at a falling edge; valid stays high for a following request.
    task automatic push_pixel(input logic [ALPHA_W-1:0] a, output bit frame_end);
        int  gap;
        bit  row_end;
        gap = pick_gap(tx_burst);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.alpha <= a;
        @(posedge i_clk);
        while (!pix_if.ready)
            @(posedge i_clk);
        pixels_sent++;
        row_end   = pos_c >= eff_w - 1;
        frame_end = row_end && (pos_r >= eff_h - 1);
        if (frame_end) begin
            pos_c = 0;
            pos_r = 0;
        end else if (row_end) begin
            pos_c = 0;
            pos_r = pos_r + 1;
        end else begin
            pos_c = pos_c + 1;
        end
        @(negedge i_clk);
    endtask

    // Run pixels until the current frame closes; pick a blob inside the current size.
    task automatic run_frame(input t_fill f);
        bit frame_end;
        fill      = f;
        blob_x0   = $urandom_range(0, eff_w - 1);
        blob_x1   = $urandom_range(blob_x0, eff_w - 1);
        blob_y0   = $urandom_range(0, eff_h - 1);
        blob_y1   = $urandom_range(blob_y0, eff_h - 1);
        frame_end = 1'b0;
        while (!frame_end)
            push_pixel(pick_alpha(), frame_end);
    endtask

    // Drop valid, wait for every predicted box to arrive, then let the pipeline empty.
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write both size registers on back-to-back edges; only while the block is idle.
    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_FRAME_WIDTH;
        cfg_data <= w;
        @(negedge i_clk);
        cfg_idx  <= REG_FRAME_HEIGHT;
        cfg_data <= h;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        eff_w = clamp_size(w);
        eff_h = clamp_size(h);
        setting_count++;
    endtask

    // Receiver: random stalls, bursts of steady ready, and the long hold-off on request.
    initial begin : box_receiver
        int stall_left;
        stall_left   = 0;
        box_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                box_if.ready <= 1'b0;
                repeat (hold_off) @(negedge i_clk);
                hold_off = 0;
                box_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                box_if.ready <= 1'b0;
                stall_left--;
            end else begin
                box_if.ready <= 1'b1;
                if (!rx_burst && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap(1'b0);
            end
        end
    end

    // Watchdog: end the run when no request moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (box_if.valid && box_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        bit frame_end;
        int rand_start;
        int n_frames;
        int k;
        logic [ALPHA_W-1:0] corner_alpha[4];

        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = REG_FRAME_WIDTH;
        cfg_data     = '0;
        pix_if.valid = 1'b0;
        pix_if.alpha = '0;
        eff_w        = MAX_DIM;
        eff_h        = MAX_DIM;
        pos_c        = 0;
        pos_r        = 0;
        fill         = FILL_EMPTY;
        corner_alpha = '{8'hFF, 8'h00, 8'h01, 8'h80};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: an empty frame, one-pixel frames over the alpha extremes,
        // and a box that sits in the last corner.
        set_frame(CFG_W'(4), CFG_W'(3));
        run_frame(FILL_EMPTY);
        settle();
        set_frame(CFG_W'(1), CFG_W'(1));
        foreach (corner_alpha[i])
            push_pixel(corner_alpha[i], frame_end);
        settle();
        set_frame(CFG_W'(3), CFG_W'(3));
        run_frame(FILL_CORNER);
        settle();

        // Shrink mid-frame: the position lies beyond the new row and the new height,
        // so the next pixel closes the frame.
        set_frame(CFG_W'(8), CFG_W'(8));
        fill = FILL_DENSE;
        repeat (20)
            push_pixel(pick_alpha(), frame_end);
        settle();
        set_frame(CFG_W'(3), CFG_W'(2));
        run_frame(FILL_DENSE);
        settle();

        // Grow mid-frame: the frame carries on under the larger size.
        set_frame(CFG_W'(2), CFG_W'(2));
        fill = FILL_SPARSE;
        push_pixel(8'h40, frame_end);
        settle();
        set_frame(CFG_W'(6), CFG_W'(5));
        run_frame(FILL_BLOB);
        settle();

        // Back pressure: one-pixel frames while the receiver holds off, so a box
        // waits in the result register and the block stops taking pixels.
        set_frame('0, '0);
        tx_burst = 1'b1;
        hold_off = HOLD_CYCLES;
        fill     = FILL_DENSE;
        repeat (60)
            push_pixel(pick_alpha(), frame_end);
        settle();
        tx_burst = 1'b0;

        // Random phases: a size setting, a few frames of mixed content, and now and
        // then a resize in the middle of a frame.
        rand_start = pixels_sent;
        while (pixels_sent - rand_start < RANDOM_PIXELS) begin
            tx_burst = ($urandom_range(0, 99) < 25);
            rx_burst = ($urandom_range(0, 99) < 25);
            set_frame(rand_width(), rand_height());
            if ($urandom_range(0, 99) < 12) begin
                fill      = t_fill'($urandom_range(FILL_EMPTY, FILL_CORNER));
                k         = $urandom_range(1, 12);
                frame_end = 1'b0;
                for (int i = 0; i < k && !frame_end; i++)
                    push_pixel(pick_alpha(), frame_end);
                settle();
                set_frame(rand_width(), rand_height());
            end
            n_frames = $urandom_range(1, 3);
            repeat (n_frames)
                run_frame(t_fill'($urandom_range(FILL_EMPTY, FILL_CORNER)));
            settle();
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;

        // Out-of-range codes act as the limits: run part of a frame under each,
        // then shrink so the frame closes soon after.
        set_frame(CFG_W'(8191), '0);
        fill = FILL_DENSE;
        repeat (PART_PIXELS)
            push_pixel(pick_alpha(), frame_end);
        settle();
        set_frame(CFG_W'(2), CFG_W'(1));
        run_frame(FILL_EDGES);
        settle();
        set_frame(CFG_W'(1), CFG_W'(5000));
        fill = FILL_DENSE;
        repeat (PART_PIXELS)
            push_pixel(pick_alpha(), frame_end);
        settle();
        set_frame(CFG_W'(1), CFG_W'(1));
        run_frame(FILL_CORNER);
        settle();
        set_frame('0, CFG_W'(4096));
        fill = FILL_SPARSE;
        repeat (PART_PIXELS)
            push_pixel(pick_alpha(), frame_end);
        settle();
        set_frame(CFG_W'(3), CFG_W'(2));
        run_frame(FILL_CORNER);
        settle();

        repeat (END_CYCLES) @(negedge i_clk);

        $display("Run covered %0d pixels and %0d boxes (%0d empty) over %0d size settings,",
                 pixels_sent, box_count, empty_count, setting_count);
        $display("with out-of-range sizes, mid-frame resizes and a long receiver hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d boxes still due", fail_count, pending);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/abbt_pkg.sv
hdl/abbt_if.sv
hdl/abbt_cfg.sv
hdl/abbt_track.sv
hdl/alpha_bounding_box_trim.sv
tb/abbt_box_checker.sv
tb/tb_top.sv
